// ===== design/assert_macros.svh =====
// Assertion helpers shared by the engine files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPL(name, clk, rst_n, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== design/i2cm_pkg.sv =====
// ----------------------------------------------------------------------------
// i2cm_pkg
// Types and constants shared by the byte-level I2C master engine.
// ----------------------------------------------------------------------------
`default_nettype none

package i2cm_pkg;

	// Command codes as they arrive on the item channel.
	typedef enum logic [2:0] {
		CMD_NONE   = 3'd0,
		CMD_START  = 3'd1,
		CMD_STOP   = 3'd2,
		CMD_WRITE  = 3'd3,
		CMD_READ   = 3'd4,
		CMD_ADDR_W = 3'd5,
		CMD_ADDR_R = 3'd6
	} cmd_t;

	// Sequencer steps of the bus engine.
	typedef enum logic [4:0] {
		ST_IDLE   = 5'd0,
		ST_S1     = 5'd1,
		ST_S2     = 5'd2,
		ST_P1     = 5'd3,
		ST_P2     = 5'd4,
		ST_P3     = 5'd5,
		ST_W_LOW  = 5'd6,
		ST_W_HIGH = 5'd7,
		ST_A_LOW  = 5'd8,
		ST_A_HIGH = 5'd9,
		ST_A_END  = 5'd10,
		ST_R_PRE  = 5'd11,
		ST_R_LOW  = 5'd12,
		ST_R_HIGH = 5'd13,
		ST_K_PRE  = 5'd14,
		ST_K_LOW  = 5'd15,
		ST_K_HIGH = 5'd16
	} step_t;

	// Configuration register indexes.
	localparam int CFG_INDEX_BITS = 1;
	localparam logic [CFG_INDEX_BITS-1:0] CFG_HALF_PERIOD = 1'd0;
	localparam logic [CFG_INDEX_BITS-1:0] CFG_SLAVE_ADDR  = 1'd1;

	localparam int            CFG_DATA_BITS     = 16;
	localparam logic [15:0]   HALF_PERIOD_RESET = 16'd100;
	localparam logic [3:0]    BITS_PER_BYTE     = 4'd8;
	localparam logic          RW_BIT_WRITE      = 1'b0;
	localparam logic          RW_BIT_READ       = 1'b1;

	// Depth of the queue between front and back; a power of two.
	localparam int QUEUE_DEPTH = 2;
	localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);
	localparam int QUEUE_CNT_BITS = $clog2(QUEUE_DEPTH + 1);

	typedef struct packed {
		logic [2:0] kind;
		logic [7:0] tx_byte;
		logic       ack_to_send;
		logic       sda_line;
	} in_t;

	typedef struct packed {
		logic       scl_drive;
		logic       sda_drive;
		logic       busy_res;
		logic       done_res;
		logic [7:0] rx_byte;
		logic       ack_received;
		logic       command_ignored;
	} out_t;

	// A classified tick as it travels through the queue.
	typedef struct packed {
		cmd_t       cmd;
		logic       is_cmd;
		logic [7:0] wr_byte;
		logic       ack_lvl;
		logic       sda;
	} item_t;

endpackage

`default_nettype wire

// ===== design/i2cm_front.sv =====
// ----------------------------------------------------------------------------
// i2cm_front
// Accepts ticks, decodes the command code and builds the byte to be sent.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module i2cm_front
	import i2cm_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       item_valid,
	output logic            item_stall,
	input  wire in_t        item_data,
	input  wire logic [6:0] slave_address,
	input  wire logic       q_full,
	output logic            q_push,
	output item_t           q_item
);

	logic  valid_s1;
	item_t item_s1;
	item_t decoded;
	logic  take;

	// The decode stage holds its tick only while the queue has no room.
	assign item_stall = valid_s1 && q_full;
	assign q_push     = valid_s1 && !q_full;
	assign q_item     = item_s1;
	assign take       = item_valid && !item_stall;

	// Address commands carry the target address and direction bit as their byte.
	always_comb begin
		decoded.is_cmd  = item_data.kind inside {[CMD_START:CMD_ADDR_R]};
		decoded.cmd     = decoded.is_cmd ? cmd_t'(item_data.kind) : CMD_NONE;
		decoded.ack_lvl = item_data.ack_to_send;
		decoded.sda     = item_data.sda_line;
		case (decoded.cmd)
			CMD_ADDR_W: decoded.wr_byte = {slave_address, RW_BIT_WRITE};
			CMD_ADDR_R: decoded.wr_byte = {slave_address, RW_BIT_READ};
			default:    decoded.wr_byte = item_data.tx_byte;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!item_stall) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			item_s1 <= decoded;
		end
	end

	`ASSERT_IMPL(a_stall_has_item, clk, arst_n, item_stall, valid_s1, "stall with empty stage")
	`ASSERT_NEXT(a_stage_held, clk, arst_n, item_stall, valid_s1, "stalled tick lost")
	`ASSERT_IMPL(a_push_room, clk, arst_n, q_push, !q_full, "push into full queue")

endmodule

`default_nettype wire

// ===== design/i2cm_fifo.sv =====
// ----------------------------------------------------------------------------
// i2cm_fifo
// Short queue that decouples the tick decoder from the bus sequencer.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module i2cm_fifo
	import i2cm_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  push,
	input  wire item_t push_item,
	input  wire logic  pop,
	output logic       full,
	output logic       empty,
	output item_t      head
);

	item_t                     mem_q [QUEUE_DEPTH];
	logic [QUEUE_PTR_BITS-1:0] wr_ptr_q;
	logic [QUEUE_PTR_BITS-1:0] rd_ptr_q;
	logic [QUEUE_CNT_BITS-1:0] count_q;

	assign full  = (count_q == QUEUE_CNT_BITS'(QUEUE_DEPTH));
	assign empty = (count_q == '0);
	assign head  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	`ASSERT_IMPL(a_count_bound, clk, arst_n, 1'b1, count_q <= QUEUE_CNT_BITS'(QUEUE_DEPTH), "queue count exceeds depth")
	`ASSERT_IMPL(a_no_pop_empty, clk, arst_n, empty, !pop, "pop from empty queue")
	`ASSERT_IMPL(a_no_push_full, clk, arst_n, full, !push, "push into full queue")

endmodule

`default_nettype wire

// ===== design/i2cm_back.sv =====
// ----------------------------------------------------------------------------
// i2cm_back
// Bus sequencer: advances the SCL/SDA phase order one tick per queue entry
// and holds each result in an output register.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module i2cm_back
	import i2cm_pkg::*;
#(
	parameter int WAIT_COUNTER_BITS = 16
)(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic [15:0] half_period_ticks,
	input  wire logic        q_empty,
	input  wire item_t       q_head,
	output logic             q_pop,
	output logic             result_valid,
	input  wire logic        result_stall,
	output out_t             result_data
);

	localparam int WCB = WAIT_COUNTER_BITS;

	step_t          step_q, step_d;
	logic [WCB-1:0] cnt_q, cnt_d;
	logic [3:0]     bc_q, bc_d;
	logic [7:0]     shift_q, shift_d;
	logic           scl_q, scl_d;
	logic           sda_q, sda_d;
	logic           ack_q, ack_d;
	logic           pend_q, pend_d;
	logic [7:0]     rx_q, rx_d;
	logic           done, ignored;
	logic           out_valid_q;
	out_t           out_q;

	logic [31:0]    hp_ext;
	logic           hp_sat;
	logic [WCB-1:0] load_val;
	logic [WCB-1:0] cnt_dec;
	logic           busy, expired;
	logic [3:0]     bc_inc;
	logic           more_bits;
	logic [7:0]     shl_wr;
	logic [7:0]     shl_rd;

	// Wait length: zero acts as one, and a short counter saturates.
	assign hp_ext   = {16'd0, half_period_ticks};
	assign hp_sat   = |(hp_ext >> WCB);
	assign load_val = hp_sat ? '1 :
		(half_period_ticks == '0) ? WCB'(1) : hp_ext[WCB-1:0];

	assign busy      = (step_q != ST_IDLE);
	assign cnt_dec   = (cnt_q == '0) ? '0 : cnt_q - 1'b1;
	assign expired   = (cnt_dec == '0);
	assign bc_inc    = bc_q + 1'b1;
	assign more_bits = (bc_inc < BITS_PER_BYTE);
	assign shl_wr    = {shift_q[6:0], 1'b0};
	assign shl_rd    = {shift_q[6:0], q_head.sda};

	assign q_pop = !q_empty && (!out_valid_q || !result_stall);

	// Next step.
	always_comb begin
		step_d = step_q;
		if (busy) begin
			if (expired) begin
				case (step_q)
					ST_S1:     step_d = ST_S2;
					ST_P1:     step_d = ST_P2;
					ST_P2:     step_d = ST_P3;
					ST_W_LOW:  step_d = ST_W_HIGH;
					ST_W_HIGH: step_d = more_bits ? ST_W_LOW : ST_A_LOW;
					ST_A_LOW:  step_d = ST_A_HIGH;
					ST_A_HIGH: step_d = ST_A_END;
					ST_R_PRE:  step_d = ST_R_LOW;
					ST_R_LOW:  step_d = ST_R_HIGH;
					ST_R_HIGH: step_d = more_bits ? ST_R_LOW : ST_K_PRE;
					ST_K_PRE:  step_d = ST_K_LOW;
					ST_K_LOW:  step_d = ST_K_HIGH;
					default:   step_d = ST_IDLE;
				endcase
			end
		end else if (q_head.is_cmd) begin
			case (q_head.cmd)
				CMD_START: step_d = ST_S1;
				CMD_STOP:  step_d = ST_P1;
				CMD_READ:  step_d = ST_R_PRE;
				default:   step_d = ST_W_LOW;
			endcase
		end
	end

	// Pins, counters and flags.
	always_comb begin
		cnt_d   = cnt_q;
		bc_d    = bc_q;
		shift_d = shift_q;
		scl_d   = scl_q;
		sda_d   = sda_q;
		ack_d   = ack_q;
		pend_d  = pend_q;
		rx_d    = rx_q;
		done    = 1'b0;
		ignored = 1'b0;
		if (busy) begin
			ignored = q_head.is_cmd;
			cnt_d   = cnt_dec;
			if (expired) begin
				cnt_d = load_val;
				case (step_q)
					ST_S1: sda_d = 1'b0;
					ST_P1: scl_d = 1'b1;
					ST_P2: sda_d = 1'b1;
					ST_W_LOW, ST_A_LOW, ST_R_LOW, ST_K_LOW: scl_d = 1'b1;
					ST_W_HIGH: begin
						scl_d   = 1'b0;
						shift_d = shl_wr;
						bc_d    = bc_inc;
						sda_d   = more_bits ? shl_wr[7] : 1'b1;
					end
					ST_A_HIGH: begin
						ack_d = !q_head.sda;
						scl_d = 1'b0;
					end
					ST_R_PRE: begin
						sda_d = 1'b1;
						scl_d = 1'b0;
					end
					ST_R_HIGH: begin
						shift_d = shl_rd;
						bc_d    = bc_inc;
						scl_d   = 1'b0;
						if (!more_bits) begin
							rx_d = shl_rd;
						end
					end
					ST_K_PRE: begin
						scl_d = 1'b0;
						sda_d = pend_q;
					end
					ST_S2: begin
						scl_d = 1'b0;
						cnt_d = '0;
						done  = 1'b1;
					end
					ST_K_HIGH: begin
						scl_d = 1'b0;
						sda_d = 1'b1;
						cnt_d = '0;
						done  = 1'b1;
					end
					default: begin
						cnt_d = '0;
						done  = 1'b1;
					end
				endcase
			end
		end else if (q_head.is_cmd) begin
			cnt_d = load_val;
			case (q_head.cmd)
				CMD_START: begin
					scl_d = 1'b1;
					sda_d = 1'b1;
				end
				CMD_STOP: begin
					scl_d = 1'b0;
					sda_d = 1'b0;
				end
				CMD_READ: begin
					pend_d  = q_head.ack_lvl;
					shift_d = '0;
					bc_d    = '0;
					scl_d   = 1'b0;
				end
				default: begin
					shift_d = q_head.wr_byte;
					bc_d    = '0;
					sda_d   = q_head.wr_byte[7];
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q      <= ST_IDLE;
			cnt_q       <= '0;
			bc_q        <= '0;
			shift_q     <= '0;
			scl_q       <= 1'b1;
			sda_q       <= 1'b1;
			ack_q       <= 1'b0;
			pend_q      <= 1'b0;
			rx_q        <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (q_pop) begin
				step_q  <= step_d;
				cnt_q   <= cnt_d;
				bc_q    <= bc_d;
				shift_q <= shift_d;
				scl_q   <= scl_d;
				sda_q   <= sda_d;
				ack_q   <= ack_d;
				pend_q  <= pend_d;
				rx_q    <= rx_d;
				out_valid_q <= 1'b1;
			end else if (!result_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			out_q.scl_drive       <= scl_d;
			out_q.sda_drive       <= sda_d;
			out_q.busy_res        <= (step_d != ST_IDLE);
			out_q.done_res        <= done;
			out_q.rx_byte         <= rx_d;
			out_q.ack_received    <= ack_d;
			out_q.command_ignored <= ignored;
		end
	end

	assign result_valid = out_valid_q;
	assign result_data  = out_q;

	`ASSERT_IMPL(a_idle_cnt, clk, arst_n, step_q == ST_IDLE, cnt_q == '0, "idle with wait pending")
	`ASSERT_IMPL(a_busy_cnt, clk, arst_n, step_q != ST_IDLE, cnt_q != '0, "busy with empty wait")
	`ASSERT_IMPL(a_done_idle, clk, arst_n, out_valid_q && out_q.done_res, !out_q.busy_res, "done while busy")
	`ASSERT_NEXT(a_pop_result, clk, arst_n, q_pop, out_valid_q, "popped tick left no result")

endmodule

`default_nettype wire

// ===== design/i2c_master_byte_engine.sv =====
// ----------------------------------------------------------------------------
// i2c_master_byte_engine
// Byte-level I2C master timing engine, one beat per bus tick.
// ----------------------------------------------------------------------------
// Every input beat is one tick of the bus timer. It carries an optional
// command (start or repeated start, stop, write byte, read byte, address
// write, address read) and the sampled SDA level, and it yields exactly one
// result beat with the SCL and SDA drive levels, busy and done flags, the
// last received byte, the last acknowledge and a flag for a command that
// was dropped because a sequence was still running. Each wait phase lasts
// half_period_ticks ticks (zero counts as one; a wait counter narrower than
// the register saturates). When neither side stalls, the block sustains one
// beat per clock: a decode stage registers and classifies each tick and forms
// the address byte, a two-entry queue separates it from the sequencer, and
// the sequencer retires one tick per cycle into an output register, so either
// side can stall on its own. A tick's result passes the decode register,
// the queue and the output register. Configuration is written through a
// plain write port; the user must write it only while the engine is idle,
// which the block does not enforce; the one-bit index has no unknown values.
// ----------------------------------------------------------------------------
`default_nettype none

module i2c_master_byte_engine
	import i2cm_pkg::*;
#(
	parameter int WAIT_COUNTER_BITS = 16
)(
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      item_valid,
	output logic                           item_stall,
	input  wire in_t                       item_data,
	output logic                           result_valid,
	input  wire logic                      result_stall,
	output out_t                           result_data,
	input  wire logic                      write_en,
	input  wire logic [CFG_INDEX_BITS-1:0] reg_index,
	input  wire logic [CFG_DATA_BITS-1:0]  write_data
);

	logic [15:0] half_period_q;
	logic [6:0]  slave_addr_q;

	logic  q_full, q_empty, q_push, q_pop;
	item_t q_item, q_head;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			half_period_q <= HALF_PERIOD_RESET;
			slave_addr_q  <= '0;
		end else if (write_en) begin
			case (reg_index)
				CFG_HALF_PERIOD: half_period_q <= write_data[15:0];
				CFG_SLAVE_ADDR:  slave_addr_q  <= write_data[6:0];
				default: ;
			endcase
		end
	end

	i2cm_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.item_valid    (item_valid),
		.item_stall    (item_stall),
		.item_data     (item_data),
		.slave_address (slave_addr_q),
		.q_full        (q_full),
		.q_push        (q_push),
		.q_item        (q_item)
	);

	i2cm_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_item (q_item),
		.pop       (q_pop),
		.full      (q_full),
		.empty     (q_empty),
		.head      (q_head)
	);

	i2cm_back #(
		.WAIT_COUNTER_BITS (WAIT_COUNTER_BITS)
	) u_back (
		.clk               (clk),
		.arst_n            (arst_n),
		.half_period_ticks (half_period_q),
		.q_empty           (q_empty),
		.q_head            (q_head),
		.q_pop             (q_pop),
		.result_valid      (result_valid),
		.result_stall      (result_stall),
		.result_data       (result_data)
	);

endmodule

`default_nettype wire
